/* sv/cfsmf_pkg.sv */
// Shared types, codes and constants of the case-folded substring match finder.
package cfsmf_pkg;

   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 21;
   localparam int SLOT_W   = 5;
   localparam int KIND_W   = 2;
   localparam int QLEN_W   = 6;
   localparam int QLEN_MAX = (1 << QLEN_W) - 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_SEL_BIT = 2;

   localparam logic REG_QUERY_LENGTH = 1'b0;
   localparam logic REG_CURSOR       = 1'b1;

   localparam logic [CMD_W-1:0] CMD_LOAD_QUERY = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEXT       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT       = 2'd2;
   localparam logic [CMD_W-1:0] CMD_PREV       = 2'd3;

   localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SELECT  = 2'd2;

   typedef enum logic {
      ST_RUN,
      ST_DIV
   } nav_state_type;

   localparam logic [CHAR_W-1:0] UPPER_A    = 21'h41;
   localparam logic [CHAR_W-1:0] UPPER_Z    = 21'h5A;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 21'h20;

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_DELTA;
      end
      return r;
   endfunction

endpackage

/* sv/cfsmf_req_if.sv */
// Input channel: commands, query and text characters.
interface cfsmf_req_if;
   logic                          valid;
   logic                          ready;
   logic [cfsmf_pkg::CMD_W-1:0]   command;
   logic [cfsmf_pkg::CHAR_W-1:0]  char_value;
   logic [cfsmf_pkg::SLOT_W-1:0]  query_index;
   logic                          end_of_text;

   modport source (output valid, command, char_value, query_index, end_of_text,
                   input ready);
   modport sink (input valid, command, char_value, query_index, end_of_text,
                 output ready);
endinterface

/* sv/cfsmf_rsp_if.sv */
// Result channel: match reports, summaries and selections.
interface cfsmf_rsp_if #(
   parameter int POSITION_WIDTH = 24,
   parameter int INDEX_WIDTH    = 10,
   parameter int TOTAL_WIDTH    = 11
);
   logic                          valid;
   logic                          ready;
   logic [cfsmf_pkg::KIND_W-1:0]  result_kind;
   logic [POSITION_WIDTH-1:0]     start_position;
   logic [POSITION_WIDTH-1:0]     end_position;
   logic [INDEX_WIDTH-1:0]        match_index;
   logic [TOTAL_WIDTH-1:0]        total_matches;
   logic                          overflow;
   logic                          last_result;

   modport source (output valid, result_kind, start_position, end_position, match_index,
                   total_matches, overflow, last_result, input ready);
   modport sink (input valid, result_kind, start_position, end_position, match_index,
                 total_matches, overflow, last_result, output ready);
endinterface

/* sv/case_folded_substring_match_finder.sv */
// Case-insensitive substring match finder. Load the query with load beats (one slot each),
// set query_length and cursor_position over the APB port, then stream text beats. Every
// overlapping occurrence gives a match beat; the text beat flagged end_of_text also gives a
// summary beat with the current match. Next/previous beats step the current match and give
// a selection beat when there are matches. One beat is taken per cycle unless the item
// stage is full or the remainder unit runs; results pass an item stage and an output
// register; a beat with a match and a summary holds input until its summary moves on.
// Match starts live in a two-port table memory (MAX_MATCHES entries, registered read),
// written as matches are found and read for summaries and selections, with the same-cycle
// write forwarded. Next/previous run a remainder unit, taking no input beat meanwhile, if
// the stepped index is at least twice the match total. No clearing pass is needed.
module case_folded_substring_match_finder #(
   parameter int MAX_QUERY      = 32,
   parameter int MAX_MATCHES    = 1024,
   parameter int POSITION_WIDTH = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   cfsmf_req_if.sink                         req,
   cfsmf_rsp_if.source                       rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cfsmf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cfsmf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cfsmf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   localparam int PW       = POSITION_WIDTH;
   localparam int QLEN_W   = cfsmf_pkg::QLEN_W;
   localparam int CHAR_W   = cfsmf_pkg::CHAR_W;
   localparam int SLOT_W   = cfsmf_pkg::SLOT_W;
   localparam int KIND_W   = cfsmf_pkg::KIND_W;
   localparam int FILL_MAX = (MAX_QUERY < cfsmf_pkg::QLEN_MAX) ? MAX_QUERY
                                                                : cfsmf_pkg::QLEN_MAX;
   localparam int IDX_W    = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
   localparam int TOT_W    = $clog2(MAX_MATCHES + 1);
   localparam int DW       = IDX_W + 1;
   localparam int CW       = $clog2(DW + 1);

   // configuration
   logic [QLEN_W-1:0] query_length_ff;
   logic [PW-1:0]     cursor_ff;
   logic              csr_we;

   // query and text window
   logic [CHAR_W-1:0] qry_ff [FILL_MAX];
   logic [CHAR_W-1:0] win_ff [FILL_MAX];
   logic [CHAR_W-1:0] win_in [FILL_MAX];
   logic [CHAR_W-1:0] qsel   [FILL_MAX];
   logic              q_we;
   logic              win_we;

   // search state
   logic [QLEN_W-1:0] fill_ff, fill_in, fill_new;
   logic [PW-1:0]     offset_ff, offset_in, offset_new;
   logic [TOT_W-1:0]  match_total_ff, match_total_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic              seen_ff, seen_in;
   logic              dropped_ff, dropped_in;

   // match datapath
   logic [QLEN_W-1:0] qlen_use;
   logic              win_eq;
   logic              hit;
   logic              first_char;
   logic [TOT_W-1:0]  tot_base, tot_after;
   logic              ovf_base, ovf_after;
   logic              seen_base, seen_after;
   logic [PW-1:0]     hit_start;
   logic              table_full, store_hit, take_cursor;
   logic [IDX_W-1:0]  hit_idx, cur_after, cur_final;

   // navigation and remainder unit
   cfsmf_pkg::nav_state_type state_ff, state_in;
   logic [DW-1:0]     tot_dw, nav_x, nav_y, div_t;
   logic              nav_fast;
   logic [IDX_W-1:0]  nav_idx;
   logic [DW-1:0]     div_num_ff, div_num_in;
   logic [DW-1:0]     div_rem_ff, div_rem_in;
   logic [CW-1:0]     div_cnt_ff, div_cnt_in;

   // match table
   logic [PW-1:0]     match_table_mem [MAX_MATCHES];
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   logic [PW-1:0]     mem_wd;
   logic [PW-1:0]     mem_q_ff;
   logic              fwd_ff;
   logic [PW-1:0]     fwd_data_ff;
   logic [PW-1:0]     tail_rd;

   // item stage
   logic              b_hit_ff, b_hit_in, b_tail_ff, b_tail_in;
   logic              b_load;
   logic [PW-1:0]     b_hit_start_ff, new_hit_start;
   logic [IDX_W-1:0]  b_hit_idx_ff, new_hit_idx;
   logic [KIND_W-1:0] b_tail_kind_ff, new_tail_kind;
   logic [IDX_W-1:0]  b_tail_idx_ff, new_tail_idx;
   logic              b_tail_zero_ff, new_tail_zero;
   logic [TOT_W-1:0]  b_total_ff, new_total;
   logic              b_ovf_ff, new_ovf;
   logic              new_hit, new_tail;
   logic              can_load_b;

   // output register
   logic              o_load;
   logic              o_valid_ff, o_valid_in;
   logic [KIND_W-1:0] o_kind_ff, o_kind_in;
   logic [PW-1:0]     o_start_ff, o_start_in;
   logic [PW-1:0]     o_end_ff, o_end_in;
   logic [IDX_W-1:0]  o_idx_ff, o_idx_in;
   logic [TOT_W-1:0]  o_total_ff;
   logic              o_ovf_ff;
   logic              o_last_ff, o_last_in;

   logic              req_fire;
   logic              is_text;

   // ---------------------------------------------------------------- APB
   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[cfsmf_pkg::CSR_SEL_BIT])
         cfsmf_pkg::REG_QUERY_LENGTH: prdata = cfsmf_pkg::CSR_DATA_W'(query_length_ff);
         cfsmf_pkg::REG_CURSOR:       prdata = cfsmf_pkg::CSR_DATA_W'(cursor_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_length_ff <= '0;
         cursor_ff       <= '0;
      end else if (csr_we) begin
         if (paddr[cfsmf_pkg::CSR_SEL_BIT] == cfsmf_pkg::REG_QUERY_LENGTH) begin
            query_length_ff <= pwdata[QLEN_W-1:0];
         end else begin
            cursor_ff <= pwdata[PW-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- match datapath
   always_comb begin
      qlen_use = (query_length_ff > QLEN_W'(FILL_MAX)) ? QLEN_W'(FILL_MAX) : query_length_ff;

      win_in[0] = cfsmf_pkg::fold_case(req.char_value);
      for (int j = 1; j < FILL_MAX; j++) begin
         win_in[j] = win_ff[j-1];
      end

      // query slot aligned to each window tap: slot qlen-1-j
      for (int j = 0; j < FILL_MAX; j++) begin
         qsel[j] = '0;
         for (int i = 0; i < FILL_MAX; i++) begin
            if ((i + j + 1) == int'(qlen_use)) begin
               qsel[j] = qsel[j] | qry_ff[i];
            end
         end
      end

      win_eq = 1'b1;
      for (int j = 0; j < FILL_MAX; j++) begin
         if (j < int'(qlen_use) && win_in[j] != qsel[j]) begin
            win_eq = 1'b0;
         end
      end

      fill_new   = (fill_ff < QLEN_W'(FILL_MAX)) ? fill_ff + QLEN_W'(1) : fill_ff;
      offset_new = (offset_ff != '1) ? offset_ff + PW'(1) : offset_ff;
      first_char = (offset_ff == '0);
      tot_base   = first_char ? '0 : match_total_ff;
      ovf_base   = first_char ? 1'b0 : dropped_ff;
      seen_base  = first_char ? 1'b0 : seen_ff;

      hit         = (qlen_use != '0) && (fill_new >= qlen_use) && win_eq;
      hit_start   = offset_ff - PW'(qlen_use) + PW'(1);
      table_full  = (tot_base == TOT_W'(MAX_MATCHES));
      store_hit   = hit && !table_full;
      hit_idx     = tot_base[IDX_W-1:0];
      take_cursor = store_hit && !seen_base && (hit_start >= cursor_ff);
      tot_after   = store_hit ? tot_base + TOT_W'(1) : tot_base;
      ovf_after   = ovf_base || (hit && table_full);
      seen_after  = seen_base || take_cursor;
      cur_after   = take_cursor ? hit_idx : cur_ff;
      cur_final   = cur_after;
      if (req.end_of_text && tot_after != '0 && !seen_after
          && TOT_W'(cur_after) >= tot_after) begin
         cur_final = '0;
      end

      tot_dw = DW'(match_total_ff);
      if (req.command == cfsmf_pkg::CMD_NEXT) begin
         nav_x = DW'(cur_ff) + DW'(1);
      end else begin
         nav_x = DW'(cur_ff) + tot_dw - DW'(1);
      end
      nav_y    = nav_x - tot_dw;
      nav_fast = (nav_x < tot_dw) || (nav_y < tot_dw);
      nav_idx  = (nav_x < tot_dw) ? nav_x[IDX_W-1:0] : nav_y[IDX_W-1:0];

      div_t = {div_rem_ff[DW-2:0], div_num_ff[DW-1]};
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      o_load     = (b_hit_ff || b_tail_ff) && (!o_valid_ff || rsp.ready);
      can_load_b = !(b_hit_ff || b_tail_ff) || (o_load && (b_hit_ff ^ b_tail_ff));

      state_in       = state_ff;
      fill_in        = fill_ff;
      offset_in      = offset_ff;
      match_total_in = match_total_ff;
      cur_in         = cur_ff;
      seen_in        = seen_ff;
      dropped_in     = dropped_ff;
      div_num_in     = div_num_ff;
      div_rem_in     = div_rem_ff;
      div_cnt_in     = div_cnt_ff;

      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = hit_idx;
      mem_wd = hit_start;
      mem_ra = cur_final;

      b_load        = 1'b0;
      new_hit       = 1'b0;
      new_tail      = 1'b0;
      new_hit_start = hit_start;
      new_hit_idx   = store_hit ? hit_idx : '0;
      new_tail_kind = cfsmf_pkg::KIND_SUMMARY;
      new_tail_idx  = '0;
      new_tail_zero = 1'b0;
      new_total     = match_total_ff;
      new_ovf       = dropped_ff;

      req.ready = 1'b0;
      req_fire  = 1'b0;
      is_text   = 1'b0;

      unique case (state_ff)
         cfsmf_pkg::ST_RUN: begin
            req.ready = can_load_b;
            req_fire  = req.valid && can_load_b;
            if (req_fire) begin
               unique case (req.command) inside
                  cfsmf_pkg::CMD_LOAD_QUERY: begin
                  end
                  cfsmf_pkg::CMD_TEXT: begin
                     is_text        = 1'b1;
                     match_total_in = tot_after;
                     dropped_in     = ovf_after;
                     seen_in        = seen_after;
                     cur_in         = cur_final;
                     mem_we         = store_hit;
                     new_total      = tot_after;
                     new_ovf        = ovf_after;
                     new_hit        = hit;
                     if (req.end_of_text) begin
                        fill_in       = '0;
                        offset_in     = '0;
                        new_tail      = 1'b1;
                        new_tail_zero = (tot_after == '0);
                        new_tail_idx  = (tot_after == '0) ? '0 : cur_final;
                        mem_re        = (tot_after != '0);
                     end else begin
                        fill_in   = fill_new;
                        offset_in = offset_new;
                     end
                     b_load = hit || req.end_of_text;
                  end
                  cfsmf_pkg::CMD_NEXT, cfsmf_pkg::CMD_PREV: begin
                     if (match_total_ff != '0) begin
                        if (nav_fast) begin
                           cur_in        = nav_idx;
                           mem_re        = 1'b1;
                           mem_ra        = nav_idx;
                           b_load        = 1'b1;
                           new_tail      = 1'b1;
                           new_tail_kind = cfsmf_pkg::KIND_SELECT;
                           new_tail_idx  = nav_idx;
                        end else begin
                           state_in   = cfsmf_pkg::ST_DIV;
                           div_num_in = nav_x;
                           div_rem_in = '0;
                           div_cnt_in = CW'(DW);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         cfsmf_pkg::ST_DIV: begin
            if (div_cnt_ff != '0) begin
               div_num_in = div_num_ff << 1;
               div_rem_in = (div_t >= tot_dw) ? div_t - tot_dw : div_t;
               div_cnt_in = div_cnt_ff - CW'(1);
            end else if (can_load_b) begin
               state_in      = cfsmf_pkg::ST_RUN;
               cur_in        = div_rem_ff[IDX_W-1:0];
               mem_re        = 1'b1;
               mem_ra        = div_rem_ff[IDX_W-1:0];
               b_load        = 1'b1;
               new_tail      = 1'b1;
               new_tail_kind = cfsmf_pkg::KIND_SELECT;
               new_tail_idx  = div_rem_ff[IDX_W-1:0];
            end
         end
         default: begin
            state_in = cfsmf_pkg::ST_RUN;
         end
      endcase

      q_we   = req_fire && (req.command == cfsmf_pkg::CMD_LOAD_QUERY);
      win_we = is_text;

      if (b_load) begin
         b_hit_in  = new_hit;
         b_tail_in = new_tail;
      end else begin
         b_hit_in  = b_hit_ff && !o_load;
         b_tail_in = b_tail_ff && !(o_load && !b_hit_ff);
      end

      // output register feed: pending match beat goes before the tail beat
      tail_rd = fwd_ff ? fwd_data_ff : mem_q_ff;
      if (b_hit_ff) begin
         o_kind_in  = cfsmf_pkg::KIND_MATCH;
         o_start_in = b_hit_start_ff;
         o_end_in   = b_hit_start_ff + PW'(qlen_use);
         o_idx_in   = b_hit_idx_ff;
         o_last_in  = !b_tail_ff;
      end else begin
         o_kind_in  = b_tail_kind_ff;
         o_start_in = b_tail_zero_ff ? '0 : tail_rd;
         o_end_in   = b_tail_zero_ff ? '0 : tail_rd + PW'(qlen_use);
         o_idx_in   = b_tail_idx_ff;
         o_last_in  = 1'b1;
      end

      if (o_load) begin
         o_valid_in = 1'b1;
      end else if (rsp.ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cfsmf_pkg::ST_RUN;
         fill_ff        <= '0;
         offset_ff      <= '0;
         match_total_ff <= '0;
         cur_ff         <= '0;
         seen_ff        <= 1'b0;
         dropped_ff     <= 1'b0;
         div_cnt_ff     <= '0;
         b_hit_ff       <= 1'b0;
         b_tail_ff      <= 1'b0;
         o_valid_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         offset_ff      <= offset_in;
         match_total_ff <= match_total_in;
         cur_ff         <= cur_in;
         seen_ff        <= seen_in;
         dropped_ff     <= dropped_in;
         div_cnt_ff     <= div_cnt_in;
         b_hit_ff       <= b_hit_in;
         b_tail_ff      <= b_tail_in;
         o_valid_ff     <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      for (int k = 0; k < FILL_MAX; k++) begin
         if (q_we && k < (1 << SLOT_W) && req.query_index == SLOT_W'(k)) begin
            qry_ff[k] <= cfsmf_pkg::fold_case(req.char_value);
         end
         if (win_we) begin
            win_ff[k] <= win_in[k];
         end
      end
      if (b_load) begin
         b_hit_start_ff <= new_hit_start;
         b_hit_idx_ff   <= new_hit_idx;
         b_tail_kind_ff <= new_tail_kind;
         b_tail_idx_ff  <= new_tail_idx;
         b_tail_zero_ff <= new_tail_zero;
         b_total_ff     <= new_total;
         b_ovf_ff       <= new_ovf;
      end
      if (o_load) begin
         o_kind_ff  <= o_kind_in;
         o_start_ff <= o_start_in;
         o_end_ff   <= o_end_in;
         o_idx_ff   <= o_idx_in;
         o_total_ff <= b_total_ff;
         o_ovf_ff   <= b_ovf_ff;
         o_last_ff  <= o_last_in;
      end
   end

   // match table; a read of the entry written in the same cycle takes the new data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         match_table_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff    <= match_table_mem[mem_ra];
         fwd_ff      <= mem_we && (mem_wa == mem_ra);
         fwd_data_ff <= mem_wd;
      end
   end

   assign rsp.valid          = o_valid_ff;
   assign rsp.result_kind    = o_kind_ff;
   assign rsp.start_position = o_start_ff;
   assign rsp.end_position   = o_end_ff;
   assign rsp.match_index    = o_idx_ff;
   assign rsp.total_matches  = o_total_ff;
   assign rsp.overflow       = o_ovf_ff;
   assign rsp.last_result    = o_last_ff;

endmodule

/* sim/tb_case_folded_substring_match_finder.sv */
// Self-checking testbench: directed and random search traffic, checked against a local predictor.
module tb_case_folded_substring_match_finder;
   import cfsmf_pkg::*;

   localparam int MAX_QUERY     = 32;
   localparam int MAX_MATCHES   = 1024;
   localparam int POS_W         = 24;
   localparam int INDEX_W       = 10;
   localparam int TOTAL_W       = 11;
   localparam int IDLE_PERCENT  = 19;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_BEATS  = 1050;
   localparam int RUN_LIMIT     = 1000000;

   localparam logic [CSR_ADDR_W-1:0] ADDR_QUERY_LENGTH =
      CSR_ADDR_W'(REG_QUERY_LENGTH) << CSR_SEL_BIT;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CURSOR = CSR_ADDR_W'(REG_CURSOR) << CSR_SEL_BIT;

   localparam logic [CHAR_W-1:0] CODE_POINT_MAX = 21'h10FFFF;
   localparam logic [CHAR_W-1:0] LOWER_A        = 21'h61;
   localparam logic [CHAR_W-1:0] LOWER_Z        = 21'h7A;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] char_value;
      logic [SLOT_W-1:0] query_index;
      logic              end_of_text;
   } search_beat_t;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   start_pos;
      logic [POS_W-1:0]   end_pos;
      logic [INDEX_W-1:0] index;
      logic [TOTAL_W-1:0] total;
      logic               overflow;
      logic               closing;
   } search_report_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cfsmf_req_if req_bus ();
   cfsmf_rsp_if #(.POSITION_WIDTH(POS_W), .INDEX_WIDTH(INDEX_W), .TOTAL_WIDTH(TOTAL_W))
      rsp_bus ();

   case_folded_substring_match_finder #(
      .MAX_QUERY(MAX_QUERY),
      .MAX_MATCHES(MAX_MATCHES),
      .POSITION_WIDTH(POS_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   search_beat_t      beats_pending[$];
   search_report_t    reports_due[$];
   search_beat_t      offered;
   int unsigned       beats_queued;
   int unsigned       error_count;
   bit                steady;
   int unsigned       holds_asked;
   int unsigned       holds_served;
   int unsigned       hold_left;
   logic [CHAR_W-1:0] stim_query [MAX_QUERY];

   // predictor state
   int unsigned        cfg_query_length;
   logic [POS_W-1:0]   cfg_cursor;
   logic [CHAR_W-1:0]  query_chars [MAX_QUERY];
   logic [CHAR_W-1:0]  window_chars [MAX_QUERY];
   int unsigned        window_count;
   logic [POS_W-1:0]   doc_offset;
   logic [POS_W-1:0]   found_starts [MAX_MATCHES];
   int unsigned        found_count;
   logic [INDEX_W-1:0] sel_index;
   bit                 cursor_hit;
   bit                 table_overflow;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
      return (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_DELTA : c;
   endfunction

   function automatic void add_report(input logic [KIND_W-1:0] kind,
                                      input logic [POS_W-1:0] start_pos,
                                      input logic [POS_W-1:0] end_pos,
                                      input logic [INDEX_W-1:0] index,
                                      input logic closing);
      reports_due.push_back('{kind, start_pos, end_pos, index, TOTAL_W'(found_count),
                              table_overflow, closing});
   endfunction

   function automatic void predict_beat(input search_beat_t b);
      int unsigned      used;
      int unsigned      i;
      int unsigned      step;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] start_pos;
      bit               hit;
      used = (cfg_query_length > MAX_QUERY) ? MAX_QUERY : cfg_query_length;
      case (b.command)
         CMD_LOAD_QUERY: begin
            query_chars[b.query_index] = b.char_value;
         end
         CMD_TEXT: begin
            pos = doc_offset;
            if (doc_offset == '0) begin
               found_count = 0;
               table_overflow = 1'b0;
               cursor_hit = 1'b0;
            end
            for (i = MAX_QUERY - 1; i > 0; i--) window_chars[i] = window_chars[i - 1];
            window_chars[0] = lower_ascii(b.char_value);
            if (window_count < MAX_QUERY) window_count++;
            if (doc_offset != '1) doc_offset++;
            if (used != 0 && window_count >= used) begin
               hit = 1'b1;
               for (i = 0; i < used; i++) begin
                  if (window_chars[used - 1 - i] != lower_ascii(query_chars[i])) hit = 1'b0;
               end
               if (hit) begin
                  start_pos = pos - POS_W'(used - 1);
                  if (found_count < MAX_MATCHES) begin
                     found_starts[found_count] = start_pos;
                     found_count++;
                     if (!cursor_hit && start_pos >= cfg_cursor) begin
                        sel_index = INDEX_W'(found_count - 1);
                        cursor_hit = 1'b1;
                     end
                     add_report(KIND_MATCH, start_pos, start_pos + POS_W'(used),
                                INDEX_W'(found_count - 1), !b.end_of_text);
                  end else begin
                     table_overflow = 1'b1;
                     add_report(KIND_MATCH, start_pos, start_pos + POS_W'(used), '0,
                                !b.end_of_text);
                  end
               end
            end
            if (b.end_of_text) begin
               if (found_count != 0) begin
                  if (!cursor_hit && sel_index >= found_count) sel_index = '0;
                  add_report(KIND_SUMMARY, found_starts[sel_index],
                             found_starts[sel_index] + POS_W'(used), sel_index, 1'b1);
               end else begin
                  add_report(KIND_SUMMARY, '0, '0, '0, 1'b1);
               end
               doc_offset = '0;
               window_count = 0;
               for (i = 0; i < MAX_QUERY; i++) window_chars[i] = '0;
            end
         end
         default: begin
            if (found_count != 0) begin
               step = (b.command == CMD_NEXT) ? 1 : found_count - 1;
               sel_index = INDEX_W'((sel_index + step) % found_count);
               add_report(KIND_SELECT, found_starts[sel_index],
                          found_starts[sel_index] + POS_W'(used), sel_index, 1'b1);
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // sender: one beat per handshake, predicted when accepted
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_beat(offered);
         if (!req_bus.valid || req_bus.ready) begin
            if (beats_pending.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               offered = beats_pending.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.command <= offered.command;
               req_bus.char_value <= offered.char_value;
               req_bus.query_index <= offered.query_index;
               req_bus.end_of_text <= offered.end_of_text;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_served <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end
   end

   always @(posedge clock) begin : take_result
      search_report_t due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (reports_due.size() == 0) begin
               $error("result kind %0d start %0h arrived with nothing expected",
                      rsp_bus.result_kind, rsp_bus.start_position);
               error_count++;
            end else begin
               due = reports_due.pop_front();
               check_field("result_kind", 32'(due.kind), 32'(rsp_bus.result_kind));
               check_field("start_position", 32'(due.start_pos), 32'(rsp_bus.start_position));
               check_field("end_position", 32'(due.end_pos), 32'(rsp_bus.end_position));
               check_field("match_index", 32'(due.index), 32'(rsp_bus.match_index));
               check_field("total_matches", 32'(due.total), 32'(rsp_bus.total_matches));
               check_field("overflow", 32'(due.overflow), 32'(rsp_bus.overflow));
               check_field("last_result", 32'(due.closing), 32'(rsp_bus.last_result));
            end
         end
         rsp_bus.ready <= hold_left == 0 && (steady || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_QUERY_LENGTH) cfg_query_length = value[QLEN_W-1:0];
      else cfg_cursor = value[POS_W-1:0];
      @(negedge clock);
   endtask

   task automatic set_search(input int unsigned qlen, input logic [POS_W-1:0] cursor);
      csr_write(ADDR_QUERY_LENGTH, CSR_DATA_W'(qlen));
      csr_write(ADDR_CURSOR, CSR_DATA_W'(cursor));
   endtask

   task automatic drain();
      while (beats_pending.size() != 0 || req_bus.valid || reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void push_beat(input logic [CMD_W-1:0] command,
                                     input logic [CHAR_W-1:0] ch,
                                     input logic [SLOT_W-1:0] slot, input logic eot);
      beats_pending.push_back('{command, ch, slot, eot});
      beats_queued++;
   endfunction

   function automatic void push_load(input int unsigned slot, input logic [CHAR_W-1:0] ch);
      stim_query[slot] = ch;
      push_beat(CMD_LOAD_QUERY, ch, SLOT_W'(slot), 1'($urandom_range(1)));
   endfunction

   function automatic void push_text(input logic [CHAR_W-1:0] ch, input logic eot);
      push_beat(CMD_TEXT, ch, SLOT_W'($urandom_range(MAX_QUERY - 1)), eot);
   endfunction

   function automatic void push_nav(input logic [CMD_W-1:0] command);
      push_beat(command, CHAR_W'($urandom_range(CODE_POINT_MAX)),
                SLOT_W'($urandom_range(MAX_QUERY - 1)), 1'($urandom_range(1)));
   endfunction

   function automatic logic [CHAR_W-1:0] vary_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] lc;
      lc = lower_ascii(c);
      if (lc >= LOWER_A && lc <= LOWER_Z && $urandom_range(1) == 1) return lc - CASE_DELTA;
      return lc;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_letter();
      return vary_case(LOWER_A + CHAR_W'($urandom_range(1)));
   endfunction

   function automatic void load_query(input int unsigned used);
      int unsigned i;
      for (i = 0; i < used; i++) push_load(i, pick_letter());
   endfunction

   // text with planted query copies, navigation and some noise, closed by end of text
   function automatic void push_document(input int unsigned used, input int unsigned span);
      int unsigned       n;
      int unsigned       i;
      int unsigned       roll;
      logic [CHAR_W-1:0] ch;
      n = 0;
      while (n < span) begin
         roll = $urandom_range(99);
         if (used != 0 && roll < 12) begin
            for (i = 0; i < used; i++) push_text(vary_case(stim_query[i]), 1'b0);
            n += used;
         end else begin
            if (roll < 20) begin
               push_nav(roll[0] ? CMD_NEXT : CMD_PREV);
            end else if (roll < 23) begin
               push_load($urandom_range(MAX_QUERY - 1), CHAR_W'($urandom_range(CODE_POINT_MAX)));
            end else if (roll < 30) begin
               push_text(CHAR_W'($urandom_range(CODE_POINT_MAX)), 1'b0);
            end else if (roll < 36) begin
               case ($urandom_range(7))
                  0: ch = 21'h40;
                  1: ch = 21'h41;
                  2: ch = 21'h5A;
                  3: ch = 21'h5B;
                  4: ch = 21'h60;
                  5: ch = 21'h7B;
                  6: ch = 21'hC1;
                  default: ch = 21'hE1;
               endcase
               push_text(ch, 1'b0);
            end else begin
               push_text(pick_letter(), 1'b0);
            end
            n++;
         end
      end
      push_text(pick_letter(), 1'b1);
   endfunction

   initial begin
      int unsigned      i;
      int unsigned      qlen;
      int unsigned      used;
      int unsigned      roll;
      int unsigned      random_start;
      logic [POS_W-1:0] cursor;
      bit               first_round;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_LOAD_QUERY;
      req_bus.char_value = '0;
      req_bus.query_index = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      beats_queued = 0;
      error_count = 0;
      steady = 1'b0;
      holds_asked = 0;
      cfg_query_length = 0;
      cfg_cursor = '0;
      window_count = 0;
      doc_offset = '0;
      found_count = 0;
      sel_index = '0;
      cursor_hit = 1'b0;
      table_overflow = 1'b0;
      for (i = 0; i < MAX_QUERY; i++) window_chars[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fold boundaries, adjacent hits, navigation with and without matches
      set_search(3, 4);
      push_nav(CMD_NEXT);
      push_nav(CMD_PREV);
      push_load(0, 21'h41);
      push_load(1, 21'h7A);
      push_load(2, 21'h40);
      push_load(31, CODE_POINT_MAX);
      push_load(30, '0);
      push_text(21'h61, 1'b0);
      push_text(21'h5A, 1'b0);
      push_text(21'h40, 1'b0);
      push_text(21'h41, 1'b0);
      push_text(21'h7A, 1'b0);
      push_text(21'h40, 1'b0);
      push_text(21'h61, 1'b0);
      push_text(21'h7A, 1'b0);
      push_text(21'h60, 1'b0);
      push_text(21'h5B, 1'b0);
      push_text(21'h41, 1'b0);
      push_text(21'h5A, 1'b0);
      push_text(21'h40, 1'b1);
      push_nav(CMD_NEXT);
      push_nav(CMD_PREV);
      push_nav(CMD_PREV);
      drain();

      // empty query
      set_search(0, '1);
      push_text(CODE_POINT_MAX, 1'b0);
      push_text('0, 1'b1);
      push_nav(CMD_NEXT);
      drain();

      // oversized query length, cursor past every match
      set_search(QLEN_MAX, '1);
      load_query(MAX_QUERY);
      push_text(pick_letter(), 1'b0);
      push_text(pick_letter(), 1'b0);
      for (i = 0; i < MAX_QUERY; i++) push_text(vary_case(stim_query[i]), 1'b0);
      push_text(pick_letter(), 1'b0);
      push_text(pick_letter(), 1'b1);
      push_nav(CMD_NEXT);
      drain();

      // match table fills up; then index far beyond a small count
      steady = 1'b1;
      set_search(1, 1000);
      push_load(0, 21'h41);
      for (i = 0; i < MAX_MATCHES + 6; i++) push_text(vary_case(LOWER_A), i == MAX_MATCHES + 5);
      push_nav(CMD_NEXT);
      push_nav(CMD_PREV);
      push_nav(CMD_PREV);
      push_text(LOWER_A, 1'b0);
      push_nav(CMD_NEXT);
      push_text(LOWER_A, 1'b0);
      push_nav(CMD_NEXT);
      push_nav(CMD_PREV);
      push_text(UPPER_A, 1'b1);
      drain();
      steady = 1'b0;

      random_start = beats_queued;
      first_round = 1'b1;
      while (beats_queued - random_start < RANDOM_BEATS) begin
         roll = $urandom_range(99);
         if (roll < 10) qlen = 0;
         else if (roll < 20) qlen = $urandom_range(MAX_QUERY, QLEN_MAX);
         else if (roll < 30) qlen = $urandom_range(5, MAX_QUERY - 1);
         else qlen = $urandom_range(1, 4);
         roll = $urandom_range(99);
         if (roll < 10) cursor = '1;
         else if (roll < 20) cursor = POS_W'($urandom);
         else if (roll < 30) cursor = '0;
         else cursor = POS_W'($urandom_range(40));
         set_search(qlen, cursor);
         used = (qlen > MAX_QUERY) ? MAX_QUERY : qlen;
         if (first_round) holds_asked++;
         first_round = 1'b0;
         load_query(used);
         repeat ($urandom_range(3, 6)) begin
            push_document(used, (used > 4) ? $urandom_range(40, 90) : $urandom_range(4, 40));
         end
         push_nav($urandom_range(1) ? CMD_NEXT : CMD_PREV);
         drain();
      end

      if (error_count == 0) begin
         $display("case_folded_substring_match_finder regression: pass");
      end else begin
         $display("case_folded_substring_match_finder regression: fail");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("case_folded_substring_match_finder regression: fail");
      $finish;
   end

endmodule
